[hdl/earliest_free_server_dispatch_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the earliest-free-server dispatch block
// Each macro expects signals named clk and arst_n in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef EARLIEST_FREE_SERVER_DISPATCH_DEFINES_SVH
`define EARLIEST_FREE_SERVER_DISPATCH_DEFINES_SVH

`ifndef SYNTHESIS
// overlapping implication: cons must hold in the same cycle as ante
`define EFSD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// non-overlapping implication: cons must hold in the cycle after ante
`define EFSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define EFSD_ASSERT_SAME(label, ante, cons, msg)
`define EFSD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[hdl/efsd_pkg.sv]
// ----------------------------------------------------------------------------
// efsd_pkg
// Shared constants, types and codes of the earliest-free-server dispatch.
// ----------------------------------------------------------------------------
`default_nettype none

package efsd_pkg;

	localparam int MAX_WINDOWS = 16;
	localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

	localparam int TIME_W = 17;
	localparam int MIN_W = 10;
	localparam int WIN_CFG_W = 5;
	localparam int VAL_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int SEC_PER_MIN = 60;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TIME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SERVICE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_OUT
	} state_t;

	// running minimum handed from cell to cell
	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] val;
		logic [IDX_W-1:0] idx;
	} cand_t;

	// free-at update broadcast to all cells
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
	} wr_t;

endpackage

`default_nettype wire

[hdl/efsd_cell.sv]
// ----------------------------------------------------------------------------
// efsd_cell
// One service window: holds its free-at time and refines the running minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module efsd_cell
	import efsd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] my_idx,
	input  wire logic [CNT_W-1:0] active_cnt,
	input  wire wr_t              wr,
	input  wire cand_t            cand_in,
	output cand_t                 cand_out
);

	logic [VAL_W-1:0] free_q;
	logic             active;
	logic             take_own;
	cand_t            cand_q;

	assign active = (32'(my_idx) < 32'(active_cnt));
	// strict compare keeps the lower index on ties
	assign take_own = !cand_in.valid || (active && (free_q < cand_in.val));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0;
		end else if (wr.en && (wr.idx == my_idx)) begin
			free_q <= wr.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else begin
			cand_q.valid <= 1'b1;
			if (take_own) begin
				cand_q.val <= free_q;
				cand_q.idx <= my_idx;
			end else begin
				cand_q.val <= cand_in.val;
				cand_q.idx <= cand_in.idx;
			end
		end
	end

	assign cand_out = cand_q;

endmodule

`default_nettype wire

[hdl/earliest_free_server_dispatch.sv]
// ----------------------------------------------------------------------------
// earliest_free_server_dispatch
// Served request: result valid after the scan through every cell (16 cells) and ST_CALC.
// Rejected request (arrival after close): result valid in the cycle after accept.
// Flow: one request in flight at a time, held while the minimum ripples
// through the cell chain, one cell per cycle, and until the result is taken.
// Reset: free-at times, totals, state and configuration at once; request and result registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "earliest_free_server_dispatch_defines.svh"

module earliest_free_server_dispatch
	import efsd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// request channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [TIME_W-1:0]    arrival_time,
	input  wire logic [MIN_W-1:0]     service_minutes,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      accepted,
	output logic [VAL_W-1:0]          wait_seconds,
	output logic [3:0]                window_index,
	output logic [VAL_W-1:0]          finish_time,
	output logic [VAL_W-1:0]          total_wait,
	output logic [VAL_W-1:0]          served_count,
	// configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TIME_W-1:0]    cfg_data
);

	// ---------------- configuration registers ----------------
	logic [TIME_W-1:0]    open_q;
	logic [TIME_W-1:0]    close_q;
	logic [MIN_W-1:0]     max_min_q;
	logic [WIN_CFG_W-1:0] windows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= TIME_W'(28800);
			close_q <= TIME_W'(61200);
			max_min_q <= MIN_W'(60);
			windows_q <= WIN_CFG_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OPEN_TIME:   open_q <= cfg_data;
				CFG_CLOSE_TIME:  close_q <= cfg_data;
				CFG_MAX_SERVICE: max_min_q <= cfg_data[MIN_W-1:0];
				CFG_WINDOWS:     windows_q <= cfg_data[WIN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the window count: zero acts as one, anything above the bank acts as the bank
	logic [CNT_W-1:0] active_cnt;
	always_comb begin
		if (windows_q == '0) begin
			active_cnt = CNT_W'(1);
		end else if (32'(windows_q) > MAX_WINDOWS) begin
			active_cnt = CNT_W'(MAX_WINDOWS);
		end else begin
			active_cnt = CNT_W'(windows_q);
		end
	end

	// ---------------- control ----------------
	state_t           state_q, state_d;
	logic [IDX_W-1:0] scan_q;
	logic             in_fire;
	logic             out_fire;
	logic             reject;
	logic             scan_done;

	assign in_fire = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;
	assign reject = (arrival_time > close_q);
	assign scan_done = (scan_q == IDX_W'(MAX_WINDOWS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs; one request in flight at a time
	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					// a rejected request skips the scan: the totals are already final
					state_d = reject ? ST_OUT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// count the cycles the minimum needs to ripple through every cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (state_q == ST_SCAN) begin
			scan_q <= scan_done ? '0 : scan_q + 1'b1;
		end else begin
			scan_q <= '0;
		end
	end

	// ---------------- cell chain ----------------
	// The chain runs freely: a minimum entering cell 0 passes the register of every
	// cell before it leaves the last one. The free-at times only change in ST_CALC,
	// so the candidate at the tail is settled by the time the scan finishes.
	cand_t cand [MAX_WINDOWS+1];
	wr_t   wr;

	assign cand[0] = '0;

	for (genvar g = 0; g < MAX_WINDOWS; g++) begin : g_cell
		efsd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.my_idx     (IDX_W'(g)),
			.active_cnt (active_cnt),
			.wr         (wr),
			.cand_in    (cand[g]),
			.cand_out   (cand[g+1])
		);
	end

	// ---------------- dispatch arithmetic ----------------
	logic [TIME_W-1:0] arr_q;
	logic [MIN_W-1:0]  min_q;
	logic [MIN_W-1:0]  svc_min;
	logic [15:0]       svc_sec;
	logic [TIME_W-1:0] start_open;
	logic [VAL_W-1:0]  best_val;
	logic [VAL_W-1:0]  start;
	logic [VAL_W-1:0]  wait_v;
	logic [VAL_W:0]    fin_sum;
	logic [VAL_W-1:0]  finish_v;
	logic [VAL_W:0]    tot_sum;
	logic [VAL_W-1:0]  tot_v;
	logic [VAL_W-1:0]  cnt_v;
	logic [VAL_W-1:0]  win_wide;

	// hold the request while it is scanned
	always_ff @(posedge clk) begin
		if (in_fire) begin
			arr_q <= arrival_time;
			min_q <= service_minutes;
		end
	end

	assign best_val = cand[MAX_WINDOWS].val;
	assign svc_min = (min_q > max_min_q) ? max_min_q : min_q;
	assign svc_sec = {6'b0, svc_min} * 16'(SEC_PER_MIN);
	assign start_open = (open_q > arr_q) ? open_q : arr_q;
	assign start = (best_val > VAL_W'(start_open)) ? best_val : VAL_W'(start_open);
	assign wait_v = start - VAL_W'(arr_q);
	assign fin_sum = {1'b0, start} + (VAL_W+1)'(svc_sec);
	assign finish_v = fin_sum[VAL_W] ? '1 : fin_sum[VAL_W-1:0];

	// saturating totals
	logic [VAL_W-1:0] wait_sum_q;
	logic [VAL_W-1:0] served_q;

	assign tot_sum = {1'b0, wait_sum_q} + {1'b0, wait_v};
	assign tot_v = tot_sum[VAL_W] ? '1 : tot_sum[VAL_W-1:0];
	assign cnt_v = (served_q == '1) ? served_q : served_q + 1'b1;
	assign win_wide = VAL_W'(cand[MAX_WINDOWS].idx);

	// drop the saturated finish into the chosen window as its new free-at time
	assign wr.en = (state_q == ST_CALC);
	assign wr.idx = cand[MAX_WINDOWS].idx;
	assign wr.val = finish_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_sum_q <= '0;
			served_q <= '0;
		end else if (state_q == ST_CALC) begin
			wait_sum_q <= tot_v;
			served_q <= cnt_v;
		end
	end

	// ---------------- result register ----------------
	logic             acc_q;
	logic [VAL_W-1:0] wait_q;
	logic [3:0]       win_q;
	logic [VAL_W-1:0] fin_q;
	logic [VAL_W-1:0] tot_q;
	logic [VAL_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (in_fire && reject) begin
			acc_q <= 1'b0;
			wait_q <= '0;
			win_q <= '0;
			fin_q <= '0;
			tot_q <= wait_sum_q;
			cnt_q <= served_q;
		end else if (state_q == ST_CALC) begin
			acc_q <= 1'b1;
			wait_q <= wait_v;
			win_q <= win_wide[3:0];
			fin_q <= finish_v;
			tot_q <= tot_v;
			cnt_q <= cnt_v;
		end
	end

	assign accepted = acc_q;
	assign wait_seconds = wait_q;
	assign window_index = win_q;
	assign finish_time = fin_q;
	assign total_wait = tot_q;
	assign served_count = cnt_q;

	// ---------------- checks ----------------
	`EFSD_ASSERT_SAME(a_one_in_flight, out_valid, in_stall, "request taken while result pending")
	`EFSD_ASSERT_SAME(a_reject_zero, out_valid && !accepted, (wait_seconds == '0) && (window_index == '0) && (finish_time == '0), "rejected result not zeroed")
	`EFSD_ASSERT_NEXT(a_calc_to_out, state_q == ST_CALC, out_valid && accepted, "calc not followed by served result")
	`EFSD_ASSERT_NEXT(a_count_hold, out_fire, served_q == $past(served_q), "served count moved outside calc")

endmodule

`default_nettype wire

[bench/earliest_free_server_dispatch_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// earliest_free_server_dispatch_tb
// Self-checking bench for the earliest-free-server dispatch block. A scoreboard
// keeps its own copy of the window free times and the running totals, predicts
// one result per accepted request and checks every result against it, while
// the sender drives bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------

module earliest_free_server_dispatch_tb
	import efsd_pkg::*;
();

	// cycles in a row with no transfer on any port before the run is abandoned
	localparam int STALL_LIMIT = 4000;
	// quiet cycles after the last result, covering the served-request latency
	localparam int SETTLE_CYCLES = MAX_WINDOWS + 8;
	localparam logic [TIME_W-1:0] LAST_SECOND = 17'd86399;

	typedef struct packed {
		logic             acc;
		logic [VAL_W-1:0] wait_s;
		logic [3:0]       win;
		logic [VAL_W-1:0] fin;
		logic [VAL_W-1:0] total;
		logic [VAL_W-1:0] count;
	} dispatch_result_t;

	// receiver stall patterns
	typedef enum int {
		SINK_OPEN,
		SINK_LIGHT,
		SINK_HEAVY,
		SINK_PERIODIC
	} sink_mode_t;

	// Scoreboard: window free times, totals and registers, plus the queue of
	// dispatch results still owed by the block.
	class dispatch_scoreboard;
		logic [TIME_W-1:0]    open_time;
		logic [TIME_W-1:0]    close_time;
		logic [MIN_W-1:0]     max_minutes;
		logic [WIN_CFG_W-1:0] windows;
		logic [VAL_W-1:0]     free_at [MAX_WINDOWS];
		logic [VAL_W-1:0]     wait_sum;
		logic [VAL_W-1:0]     served;
		dispatch_result_t     owed_q[$];
		int                   errors;

		function new();
			open_time = 17'd28800;
			close_time = 17'd61200;
			max_minutes = 10'd60;
			windows = 5'd16;
			foreach (free_at[i])
				free_at[i] = '0;
			wait_sum = '0;
			served = '0;
			errors = 0;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function logic [VAL_W-1:0] sat_add(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
			logic [VAL_W:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[VAL_W] ? '1 : s[VAL_W-1:0];
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
			case (idx)
				CFG_OPEN_TIME: open_time = data;
				CFG_CLOSE_TIME: close_time = data;
				CFG_MAX_SERVICE: max_minutes = data[MIN_W-1:0];
				CFG_WINDOWS: windows = data[WIN_CFG_W-1:0];
				default: ;
			endcase
		endfunction

		// dispatch one accepted request and queue what the block must return
		function void note_request(logic [TIME_W-1:0] arr, logic [MIN_W-1:0] mins);
			dispatch_result_t r;
			int               n_active;
			int               best;
			logic [MIN_W-1:0] capped;
			logic [VAL_W-1:0] start_s;
			r = '0;
			if (arr <= close_time) begin
				n_active = int'(windows);
				if (n_active < 1)
					n_active = 1;
				if (n_active > MAX_WINDOWS)
					n_active = MAX_WINDOWS;
				best = 0;
				for (int i = 1; i < n_active; i++)
					if (free_at[i] < free_at[best])
						best = i;
				capped = (mins > max_minutes) ? max_minutes : mins;
				start_s = VAL_W'(arr);
				if (VAL_W'(open_time) > start_s)
					start_s = VAL_W'(open_time);
				if (free_at[best] > start_s)
					start_s = free_at[best];
				r.acc = 1'b1;
				r.wait_s = start_s - VAL_W'(arr);
				r.win = 4'(best);
				r.fin = sat_add(start_s, VAL_W'(capped) * 32'(SEC_PER_MIN));
				free_at[best] = r.fin;
				wait_sum = sat_add(wait_sum, r.wait_s);
				served = sat_add(served, 32'd1);
			end
			r.total = wait_sum;
			r.count = served;
			owed_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
			if (want !== got) begin
				$display("%0t ERROR %s mismatch: expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(dispatch_result_t got);
			dispatch_result_t want;
			if (owed_q.size() == 0) begin
				$display("%0t ERROR result with nothing owed: acc %0b wait %0d win %0d fin %0d",
					$time, got.acc, got.wait_s, got.win, got.fin);
				errors++;
			end else begin
				want = owed_q.pop_front();
				compare_field("accepted", VAL_W'(want.acc), VAL_W'(got.acc));
				compare_field("wait_seconds", want.wait_s, got.wait_s);
				compare_field("window_index", VAL_W'(want.win), VAL_W'(got.win));
				compare_field("finish_time", want.fin, got.fin);
				compare_field("total_wait", want.total, got.total);
				compare_field("served_count", want.count, got.count);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [TIME_W-1:0]    arrival_time = '0;
	logic [MIN_W-1:0]     service_minutes = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 accepted;
	logic [VAL_W-1:0]     wait_seconds;
	logic [3:0]           window_index;
	logic [VAL_W-1:0]     finish_time;
	logic [VAL_W-1:0]     total_wait;
	logic [VAL_W-1:0]     served_count;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_OPEN_TIME;
	logic [TIME_W-1:0]    cfg_data = '0;

	dispatch_scoreboard sb = new();
	int burst_left = 0;
	int results_seen = 0;
	bit hold_done = 1'b0;

	earliest_free_server_dispatch i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.arrival_time    (arrival_time),
		.service_minutes (service_minutes),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.accepted        (accepted),
		.wait_seconds    (wait_seconds),
		.window_index    (window_index),
		.finish_time     (finish_time),
		.total_wait      (total_wait),
		.served_count    (served_count),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offer one request and hold it until the block takes it. Between bursts,
	// drop valid for a random gap; inside a burst, keep valid high and just
	// swap the payload on the accepting edge.
	task automatic send_request(input logic [TIME_W-1:0] arr, input logic [MIN_W-1:0] mins);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		arrival_time <= arr;
		service_minutes <= mins;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(arr, mins);
		burst_left--;
	endtask

	// Stop offering, wait until every owed result is back, then give the block
	// its served-request latency to return to idle.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Drain, then write all four registers on consecutive edges.
	task automatic configure(input logic [TIME_W-1:0] open_s, input logic [TIME_W-1:0] close_s,
			input logic [TIME_W-1:0] max_m, input logic [TIME_W-1:0] win);
		logic [CFG_IDX_W-1:0] idx_list [4];
		logic [TIME_W-1:0]    data_list [4];
		idx_list = '{CFG_OPEN_TIME, CFG_CLOSE_TIME, CFG_MAX_SERVICE, CFG_WINDOWS};
		data_list = '{open_s, close_s, max_m, win};
		drain();
		cfg_we <= 1'b1;
		for (int k = 0; k < 4; k++) begin
			cfg_index <= idx_list[k];
			cfg_data <= data_list[k];
			@(posedge clk);
			sb.write_reg(idx_list[k], data_list[k]);
		end
		cfg_we <= 1'b0;
	endtask

	// Directed requests: field extremes, close-time boundary, window count out
	// of range both ways, ties on free times and out-of-order arrivals.
	task automatic run_directed();
		// reset registers: open 8:00, close 17:00, 60 minute cap, 16 windows
		send_request('0, '0);                // before opening, zero length
		send_request('0, 10'd1023);          // capped, lands on a tied window
		send_request(17'd61200, 10'd60);     // exactly at closing: served
		send_request(17'd61201, 10'd5);      // one second late: rejected
		send_request(LAST_SECOND, 10'd1023); // end of day: rejected
		send_request(17'd30000, 10'd10);
		send_request(17'd29000, 10'd10);     // earlier than the previous request
		// zero windows behaves as one, all-day hours, no cap in effect
		configure('0, LAST_SECOND, 17'd1023, 17'd0);
		send_request('0, 10'd1023);
		send_request(17'd100, 10'd1);
		send_request(LAST_SECOND, '0);
		send_request(LAST_SECOND, 10'd1023);
		// too many windows clamps to all of them; open after close
		configure(LAST_SECOND, '0, '0, 17'd31);
		send_request('0, 10'd1023);
		send_request(17'd1, 10'd5);
		send_request('0, '0);
		// full range again, bit patterns across both fields
		configure('0, LAST_SECOND, 17'd1023, 17'd16);
		send_request(17'd65536, 10'd512);
		send_request(17'd21845, 10'd682);
		send_request(17'd43690, 10'd341);
		send_request(LAST_SECOND, 10'd1023);
		send_request('0, '0);
		// single window, one minute cap
		configure(17'd100, 17'd50000, 17'd1, 17'd1);
		send_request(17'd50, 10'd2);
		send_request(17'd60, 10'd1);
		send_request(17'd200, '0);
	endtask

	function automatic logic [TIME_W-1:0] pick_second();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return LAST_SECOND;
			default: return TIME_W'($urandom_range(0, 86399));
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] pick_max_minutes();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 17'd1023;
			2: return TIME_W'($urandom_range(0, 1023));
			default: return TIME_W'($urandom_range(1, 90));
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] pick_windows();
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return 17'd1;
			2: return 17'd16;
			3: return TIME_W'($urandom_range(17, 31));
			default: return TIME_W'($urandom_range(1, 16));
		endcase
	endfunction

	// One phase of random requests: mostly a rising stream of arrivals from a
	// random start, with some arrivals thrown anywhere in the day.
	task automatic run_random_phase(input int count);
		logic [TIME_W-1:0] arr;
		logic [MIN_W-1:0]  mins;
		int                t;
		t = $urandom_range(0, 70000);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				arr = TIME_W'($urandom_range(0, 86399));
			end else begin
				t += $urandom_range(0, 900);
				if (t > 86399)
					t = 86399;
				arr = TIME_W'(t);
			end
			case ($urandom_range(0, 7))
				0: mins = '0;
				1: mins = 10'd1023;
				2, 3: mins = MIN_W'($urandom_range(0, 1023));
				default: mins = MIN_W'($urandom_range(0, 45));
			endcase
			send_request(arr, mins);
		end
	endtask

	// Stimulus: reset, directed checks, random phases, then one long phase that
	// drives the running wait total into saturation.
	initial begin : stimulus
		int random_sent;
		int n;
		int t;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		random_sent = 0;
		while (random_sent < 180) begin
			n = $urandom_range(20, 60);
			configure(($urandom_range(0, 2) == 0) ? pick_second() : TIME_W'($urandom_range(0, 40000)),
				($urandom_range(0, 3) == 0) ? pick_second() : TIME_W'($urandom_range(40000, 86399)),
				pick_max_minutes(), pick_windows());
			run_random_phase(n);
			random_sent += n;
		end
		// one window, full cap: waits pile up until total_wait saturates
		configure('0, LAST_SECOND, 17'd1023, 17'd1);
		t = 0;
		for (int k = 0; k < 400; k++) begin
			t += $urandom_range(0, 3);
			send_request(TIME_W'(t), 10'd1023);
		end
		drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Result side: check every result as it is taken, then pick the next stall value.
	// Once, with the sender still offering, hold off long enough to back the
	// block up into its request port.
	initial begin : result_sink
		sink_mode_t mode;
		int         mode_left;
		int         hold_left;
		int         tick;
		mode = SINK_OPEN;
		mode_left = 0;
		hold_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (out_valid && !out_stall) begin
				sb.check_result('{accepted, wait_seconds, window_index, finish_time,
					total_wait, served_count});
				results_seen++;
			end
			if (!hold_done && results_seen >= 150 && in_valid) begin
				hold_left = 400;
				hold_done = 1'b1;
			end
			if (mode_left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					SINK_OPEN: out_stall <= 1'b0;
					SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					SINK_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ((tick % 5) < 2);
				endcase
			end
		end
	end

	// Watchdog: abandon the run after too many cycles without any transfer.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("tb: failure");
		$finish;
	end

endmodule
